/* hdl/nearest_k_entity_selector_macros.svh */
// Assertion helpers shared by the selector modules.
// All checks are clocked on aclk and held off while aresetn is low.
`ifndef NEAREST_K_ENTITY_SELECTOR_MACROS_SVH
`define NEAREST_K_ENTITY_SELECTOR_MACROS_SVH

// Same-cycle implication
`define NKES_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define NKES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/nkes_pkg.sv */
`default_nettype none
package nkes_pkg;

    // Default table depth
    localparam int MAX_ENTRIES_DEF = 256;

    // Field widths
    localparam int COORD_W    = 19;
    localparam int ENT_W      = 11;
    localparam int DIST_W     = 42;
    localparam int CAP_W      = 9;
    localparam int SLOT_W     = 8;
    localparam int COUNT_W    = 9;
    localparam int FUNC_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;
    localparam int ABS_W      = 20;
    localparam int SQ_W       = 40;
    localparam int AXIS_W     = 2;

    // Item functions
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_OFFER = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd4;

    // Axis codes
    localparam logic [AXIS_W-1:0] AXIS_X   = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y   = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z   = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_FIN = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic              latch;
        logic              dist_mul;
        logic              dist_clr;
        logic              dist_acc;
        logic [AXIS_W-1:0] axis;
        logic              clear;
        logic              append;
        logic              scan_init;
        logic              scan_rd;
        logic              shift_rd;
        logic              evict;
        logic              replace;
        logic              read_slot;
        logic              read_cap;
        logic              out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic room;
        logic mode;
        logic held_nz;
        logic idx_last;
        logic evict;
        logic best_last;
        logic slot_ok;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

/* hdl/nkes_ram.sv */
`default_nettype none
module nkes_ram #(
    parameter int WIDTH = 53,
    parameter int DEPTH = 256
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

/* hdl/nkes_ctrl.sv */
`default_nettype none
module nkes_ctrl (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    input  wire logic [nkes_pkg::FUNC_W-1:0] s_func,
    input  wire nkes_pkg::sts_t             sts,
    output nkes_pkg::cmd_t                  cmd,
    output logic                            s_ready
);
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CLEAR     = 4'd1;
    localparam logic [3:0] S_DIST      = 4'd2;
    localparam logic [3:0] S_DECIDE    = 4'd3;
    localparam logic [3:0] S_SCAN      = 4'd4;
    localparam logic [3:0] S_SCAN_END  = 4'd5;
    localparam logic [3:0] S_EVAL      = 4'd6;
    localparam logic [3:0] S_SHIFT     = 4'd7;
    localparam logic [3:0] S_SHIFT_END = 4'd8;
    localparam logic [3:0] S_WRITE     = 4'd9;
    localparam logic [3:0] S_READ      = 4'd10;
    localparam logic [3:0] S_RDWAIT    = 4'd11;
    localparam logic [3:0] S_DONE      = 4'd12;

    logic [3:0]                      state_reg, state_next;
    logic [nkes_pkg::AXIS_W-1:0]     axis_reg, axis_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            axis_reg  <= nkes_pkg::AXIS_X;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch = 1'b1;
                    axis_next = nkes_pkg::AXIS_X;
                    unique case (s_func)
                        nkes_pkg::FUNC_CLEAR: state_next = S_CLEAR;
                        nkes_pkg::FUNC_OFFER: state_next = S_DIST;
                        nkes_pkg::FUNC_READ:  state_next = S_READ;
                        default:              state_next = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                cmd.clear  = 1'b1;
                state_next = S_DONE;
            end
            S_DIST: begin
                // one square per axis, accumulated in the next cycle
                cmd.dist_mul = (axis_reg != nkes_pkg::AXIS_FIN);
                cmd.dist_clr = (axis_reg == nkes_pkg::AXIS_X);
                cmd.dist_acc = (axis_reg != nkes_pkg::AXIS_X);
                axis_next    = axis_reg + 2'd1;
                if (axis_reg == nkes_pkg::AXIS_FIN) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (sts.room) begin
                    cmd.append = 1'b1;
                    state_next = S_DONE;
                end else if (sts.mode && sts.held_nz) begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (sts.idx_last) begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (sts.evict) begin
                    cmd.evict  = 1'b1;
                    state_next = sts.best_last ? S_WRITE : S_SHIFT;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT: begin
                cmd.shift_rd = 1'b1;
                if (sts.idx_last) begin
                    state_next = S_SHIFT_END;
                end
            end
            S_SHIFT_END: begin
                state_next = S_WRITE;
            end
            S_WRITE: begin
                cmd.replace = 1'b1;
                state_next  = S_DONE;
            end
            S_READ: begin
                if (sts.slot_ok) begin
                    cmd.read_slot = 1'b1;
                    state_next    = S_RDWAIT;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_RDWAIT: begin
                cmd.read_cap = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

/* hdl/nkes_datapath.sv */
`default_nettype none
module nkes_datapath #(
    parameter int MAX_ENTRIES = nkes_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_valid,
    input  wire logic [nkes_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [nkes_pkg::CFG_DATA_W-1:0]   cfg_data,
    // item
    input  wire logic [nkes_pkg::ENT_W-1:0]        s_entity_number,
    input  wire logic signed [nkes_pkg::COORD_W-1:0] s_box_min_x,
    input  wire logic signed [nkes_pkg::COORD_W-1:0] s_box_min_y,
    input  wire logic signed [nkes_pkg::COORD_W-1:0] s_box_min_z,
    input  wire logic signed [nkes_pkg::COORD_W-1:0] s_box_max_x,
    input  wire logic signed [nkes_pkg::COORD_W-1:0] s_box_max_y,
    input  wire logic signed [nkes_pkg::COORD_W-1:0] s_box_max_z,
    input  wire logic [nkes_pkg::SLOT_W-1:0]       s_slot_index,
    // control
    input  wire nkes_pkg::cmd_t                    cmd,
    output nkes_pkg::sts_t                         sts,
    // result
    input  wire logic                              m_ready,
    output logic                                   m_valid,
    output logic                                   m_accepted,
    output logic [nkes_pkg::SLOT_W-1:0]            m_stored_position,
    output logic                                   m_evicted_valid,
    output logic [nkes_pkg::ENT_W-1:0]             m_evicted_entity,
    output logic [nkes_pkg::COUNT_W-1:0]           m_entry_count,
    output logic [nkes_pkg::ENT_W-1:0]             m_read_entity,
    output logic [nkes_pkg::DIST_W-1:0]            m_read_distance
);
    `include "nearest_k_entity_selector_macros.svh"

    localparam int COORD_W = nkes_pkg::COORD_W;
    localparam int ENT_W   = nkes_pkg::ENT_W;
    localparam int DIST_W  = nkes_pkg::DIST_W;
    localparam int SLOT_W  = nkes_pkg::SLOT_W;
    localparam int COUNT_W = nkes_pkg::COUNT_W;
    localparam int CAP_W   = nkes_pkg::CAP_W;
    localparam int ABS_W   = nkes_pkg::ABS_W;
    localparam int SQ_W    = nkes_pkg::SQ_W;
    localparam int WORD_W  = ENT_W + DIST_W;
    localparam int ADDR_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int CW      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int SW      = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    // configuration registers
    logic signed [COORD_W-1:0] view_x_reg, view_y_reg, view_z_reg;
    logic [CAP_W-1:0]          cap_reg;
    logic                      mode_reg;

    // item registers
    logic [ENT_W-1:0]          ent_reg;
    logic signed [COORD_W-1:0] lo_x_reg, lo_y_reg, lo_z_reg;
    logic signed [COORD_W-1:0] hi_x_reg, hi_y_reg, hi_z_reg;
    logic [SLOT_W-1:0]         slot_reg;

    // working registers
    logic [SQ_W-1:0]   prod_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [CNT_W-1:0]  held_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [DIST_W-1:0] far_reg;
    logic [ENT_W-1:0]  far_ent_reg;
    logic [ADDR_W-1:0] best_reg;
    logic              pv_reg;
    logic              pcopy_reg;
    logic [ADDR_W-1:0] pidx_reg;

    // staged result
    logic              res_acc_reg, res_ev_reg;
    logic [SLOT_W-1:0] res_pos_reg;
    logic [ENT_W-1:0]  res_ev_ent_reg, res_rent_reg;
    logic [DIST_W-1:0] res_rdist_reg;

    // output register
    logic              m_valid_reg;
    logic              out_acc_reg, out_ev_reg;
    logic [SLOT_W-1:0] out_pos_reg;
    logic [ENT_W-1:0]  out_ev_ent_reg, out_rent_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [DIST_W-1:0] out_rdist_reg;

    // RAM ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
    logic [WORD_W-1:0] ram_wr_data, ram_rd_data;
    logic [ENT_W-1:0]  rd_ent;
    logic [DIST_W-1:0] rd_dist;

    logic [CNT_W-1:0]  held_m1;
    logic [CW-1:0]     cap_eff;
    logic signed [COORD_W-1:0] ax_view, ax_lo, ax_hi;
    logic signed [COORD_W+1:0] ax_diff;
    logic [ABS_W-1:0]  ax_abs;
    logic [SQ_W-1:0]   ax_sq;

    assign held_m1 = held_reg - CNT_W'(1);
    assign rd_ent  = ram_rd_data[WORD_W-1:DIST_W];
    assign rd_dist = ram_rd_data[DIST_W-1:0];

    // capacity saturated to the table depth
    always_comb begin
        if (CW'(cap_reg) > CW'(MAX_ENTRIES)) begin
            cap_eff = CW'(MAX_ENTRIES);
        end else begin
            cap_eff = CW'(cap_reg);
        end
    end

    // per-axis doubled centre offset, magnitude and square
    always_comb begin
        case (cmd.axis)
            nkes_pkg::AXIS_X: begin
                ax_view = view_x_reg; ax_lo = lo_x_reg; ax_hi = hi_x_reg;
            end
            nkes_pkg::AXIS_Y: begin
                ax_view = view_y_reg; ax_lo = lo_y_reg; ax_hi = hi_y_reg;
            end
            default: begin
                ax_view = view_z_reg; ax_lo = lo_z_reg; ax_hi = hi_z_reg;
            end
        endcase
        ax_diff = {ax_view[COORD_W-1], ax_view, 1'b0}
                - {{2{ax_lo[COORD_W-1]}}, ax_lo}
                - {{2{ax_hi[COORD_W-1]}}, ax_hi};
        if (ax_diff[COORD_W+1]) begin
            ax_abs = ~ax_diff[ABS_W-1:0] + ABS_W'(1);
        end else begin
            ax_abs = ax_diff[ABS_W-1:0];
        end
        ax_sq = ax_abs * ax_abs;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_x_reg <= '0;
            view_y_reg <= '0;
            view_z_reg <= '0;
            cap_reg    <= CAP_W'(64);
            mode_reg   <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                nkes_pkg::CFG_VIEWER_X: view_x_reg <= cfg_data;
                nkes_pkg::CFG_VIEWER_Y: view_y_reg <= cfg_data;
                nkes_pkg::CFG_VIEWER_Z: view_z_reg <= cfg_data;
                nkes_pkg::CFG_CAPACITY: cap_reg    <= cfg_data[CAP_W-1:0];
                nkes_pkg::CFG_MODE:     mode_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            ent_reg  <= s_entity_number;
            lo_x_reg <= s_box_min_x;
            lo_y_reg <= s_box_min_y;
            lo_z_reg <= s_box_min_z;
            hi_x_reg <= s_box_max_x;
            hi_y_reg <= s_box_max_y;
            hi_z_reg <= s_box_max_z;
            slot_reg <= s_slot_index;
        end
    end

    // distance accumulation, zero in plain mode
    always_ff @(posedge aclk) begin
        if (cmd.dist_mul) begin
            prod_reg <= ax_sq;
        end
        if (cmd.dist_clr) begin
            dist_reg <= '0;
        end else if (cmd.dist_acc) begin
            dist_reg <= mode_reg ? (dist_reg + DIST_W'(prod_reg)) : '0;
        end
    end

    // fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else if (cmd.clear) begin
            held_reg <= '0;
        end else if (cmd.append) begin
            held_reg <= held_reg + CNT_W'(1);
        end
    end

    // sweep counter and read pipe tag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else begin
            pv_reg <= cmd.scan_rd | cmd.shift_rd;
        end
        if (cmd.scan_init) begin
            idx_reg <= '0;
        end else if (cmd.evict) begin
            idx_reg <= CNT_W'(best_reg) + CNT_W'(1);
        end else if (cmd.scan_rd || cmd.shift_rd) begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
        pcopy_reg <= cmd.shift_rd;
        pidx_reg  <= idx_reg[ADDR_W-1:0];
    end

    // farthest search: first entry with the largest distance wins
    always_ff @(posedge aclk) begin
        if (pv_reg && !pcopy_reg) begin
            if ((pidx_reg == '0) || (rd_dist > far_reg)) begin
                far_reg     <= rd_dist;
                far_ent_reg <= rd_ent;
                best_reg    <= pidx_reg;
            end
        end
    end

    // RAM addressing
    always_comb begin
        ram_we      = 1'b0;
        ram_wr_addr = held_reg[ADDR_W-1:0];
        ram_wr_data = {ent_reg, dist_reg};
        if (cmd.read_slot) begin
            ram_rd_addr = ADDR_W'(slot_reg);
        end else begin
            ram_rd_addr = idx_reg[ADDR_W-1:0];
        end
        if (cmd.append) begin
            ram_we = 1'b1;
        end else if (cmd.replace) begin
            ram_we      = 1'b1;
            ram_wr_addr = held_m1[ADDR_W-1:0];
        end else if (pv_reg && pcopy_reg) begin
            // shift down one slot
            ram_we      = 1'b1;
            ram_wr_addr = pidx_reg - ADDR_W'(1);
            ram_wr_data = ram_rd_data;
        end
    end

    nkes_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ENTRIES)
    ) u_slots (
        .aclk    (aclk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // staged result fields
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            res_acc_reg    <= 1'b0;
            res_pos_reg    <= '0;
            res_ev_reg     <= 1'b0;
            res_ev_ent_reg <= '0;
            res_rent_reg   <= '0;
            res_rdist_reg  <= '0;
        end else begin
            if (cmd.append) begin
                res_acc_reg <= 1'b1;
                res_pos_reg <= SLOT_W'(held_reg);
            end
            if (cmd.replace) begin
                res_acc_reg <= 1'b1;
                res_pos_reg <= SLOT_W'(held_m1);
            end
            if (cmd.evict) begin
                res_ev_reg     <= 1'b1;
                res_ev_ent_reg <= far_ent_reg;
            end
            if (cmd.read_cap) begin
                res_rent_reg  <= rd_ent;
                res_rdist_reg <= rd_dist;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_acc_reg    <= res_acc_reg;
            out_pos_reg    <= res_pos_reg;
            out_ev_reg     <= res_ev_reg;
            out_ev_ent_reg <= res_ev_ent_reg;
            out_count_reg  <= COUNT_W'(held_reg);
            out_rent_reg   <= res_rent_reg;
            out_rdist_reg  <= res_rdist_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_accepted        = out_acc_reg;
    assign m_stored_position = out_pos_reg;
    assign m_evicted_valid   = out_ev_reg;
    assign m_evicted_entity  = out_ev_ent_reg;
    assign m_entry_count     = out_count_reg;
    assign m_read_entity     = out_rent_reg;
    assign m_read_distance   = out_rdist_reg;

    // status to the controller
    always_comb begin
        sts           = '0;
        sts.room      = CW'(held_reg) < cap_eff;
        sts.mode      = mode_reg;
        sts.held_nz   = (held_reg != '0);
        sts.idx_last  = (idx_reg == held_m1);
        sts.evict     = (far_reg > dist_reg);
        sts.best_last = (CNT_W'(best_reg) == held_m1);
        sts.slot_ok   = SW'(slot_reg) < SW'(held_reg);
        sts.out_free  = !m_valid_reg || m_ready;
    end

    `NKES_ASSERT_NOW(a_held_bound, 1'b1, held_reg <= CNT_W'(MAX_ENTRIES), "fill count above depth")
    `NKES_ASSERT_NOW(a_append_room, cmd.append, sts.room, "append into full table")
    `NKES_ASSERT_NOW(a_load_free, cmd.out_load, sts.out_free, "result overwritten")
    `NKES_ASSERT_NOW(a_copy_addr, pv_reg && pcopy_reg, pidx_reg != '0, "shift below slot zero")
    `NKES_ASSERT_NEXT(a_append_count, cmd.append, held_reg != '0, "append left count at zero")
endmodule
`default_nettype wire

/* hdl/nearest_k_entity_selector.sv */
`default_nettype none
// Nearest-k entity selector: keeps an ordered table of up to MAX_ENTRIES entities
// nearest the viewer, one result per item in item order. An item is taken only
// while the block is idle; its result waits in an output register, so the next item
// may be taken while that result is still unclaimed. An offer to a full table in
// distance mode adds a sweep over the one-read-port slot RAM to find the farthest
// entry; if it is farther than the offer, the entries after it shift down and the
// new entry is written to the last slot. The distance takes one multiplier pass
// per axis. No clearing pass is run after reset.
module nearest_k_entity_selector #(
    parameter int MAX_ENTRIES = nkes_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [nkes_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [nkes_pkg::CFG_DATA_W-1:0]     cfg_data,
    // items
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [nkes_pkg::FUNC_W-1:0]         s_func,
    input  wire logic [nkes_pkg::ENT_W-1:0]          s_entity_number,
    input  wire logic signed [nkes_pkg::COORD_W-1:0] s_box_min_x,
    input  wire logic signed [nkes_pkg::COORD_W-1:0] s_box_min_y,
    input  wire logic signed [nkes_pkg::COORD_W-1:0] s_box_min_z,
    input  wire logic signed [nkes_pkg::COORD_W-1:0] s_box_max_x,
    input  wire logic signed [nkes_pkg::COORD_W-1:0] s_box_max_y,
    input  wire logic signed [nkes_pkg::COORD_W-1:0] s_box_max_z,
    input  wire logic [nkes_pkg::SLOT_W-1:0]         s_slot_index,
    // results
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_accepted,
    output logic [nkes_pkg::SLOT_W-1:0]              m_stored_position,
    output logic                                     m_evicted_valid,
    output logic [nkes_pkg::ENT_W-1:0]               m_evicted_entity,
    output logic [nkes_pkg::COUNT_W-1:0]             m_entry_count,
    output logic [nkes_pkg::ENT_W-1:0]               m_read_entity,
    output logic [nkes_pkg::DIST_W-1:0]              m_read_distance
);
    nkes_pkg::cmd_t cmd;
    nkes_pkg::sts_t sts;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    nkes_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .sts     (sts),
        .cmd     (cmd),
        .s_ready (s_ready)
    );

    nkes_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_entity_number   (s_entity_number),
        .s_box_min_x       (s_box_min_x),
        .s_box_min_y       (s_box_min_y),
        .s_box_min_z       (s_box_min_z),
        .s_box_max_x       (s_box_max_x),
        .s_box_max_y       (s_box_max_y),
        .s_box_max_z       (s_box_max_z),
        .s_slot_index      (s_slot_index),
        .cmd               (cmd),
        .sts               (sts),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_accepted        (m_accepted),
        .m_stored_position (m_stored_position),
        .m_evicted_valid   (m_evicted_valid),
        .m_evicted_entity  (m_evicted_entity),
        .m_entry_count     (m_entry_count),
        .m_read_entity     (m_read_entity),
        .m_read_distance   (m_read_distance)
    );
endmodule
`default_nettype wire

/* tb/sv/tb_nearest_k_entity_selector.sv */
`timescale 1ns / 100ps
module tb_nearest_k_entity_selector;
    import nkes_pkg::*;

    localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 100;

    typedef struct {
        logic [FUNC_W-1:0]         func;
        logic [ENT_W-1:0]          ent;
        logic signed [COORD_W-1:0] bmin [3];
        logic signed [COORD_W-1:0] bmax [3];
        logic [SLOT_W-1:0]         slot;
    } entity_item_t;

    typedef struct {
        logic                accepted;
        logic [SLOT_W-1:0]   pos;
        logic                ev_valid;
        logic [ENT_W-1:0]    ev_ent;
        logic [COUNT_W-1:0]  count;
        logic [ENT_W-1:0]    rd_ent;
        logic [DIST_W-1:0]   rd_dist;
    } selection_t;

    logic aclk;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic [FUNC_W-1:0] s_func;
    logic [ENT_W-1:0] s_entity_number;
    logic signed [COORD_W-1:0] s_box_min_x, s_box_min_y, s_box_min_z;
    logic signed [COORD_W-1:0] s_box_max_x, s_box_max_y, s_box_max_z;
    logic [SLOT_W-1:0] s_slot_index;
    logic m_valid;
    logic m_ready;
    logic m_accepted;
    logic [SLOT_W-1:0] m_stored_position;
    logic m_evicted_valid;
    logic [ENT_W-1:0] m_evicted_entity;
    logic [COUNT_W-1:0] m_entry_count;
    logic [ENT_W-1:0] m_read_entity;
    logic [DIST_W-1:0] m_read_distance;

    nearest_k_entity_selector uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_entity_number(s_entity_number),
        .s_box_min_x(s_box_min_x), .s_box_min_y(s_box_min_y), .s_box_min_z(s_box_min_z),
        .s_box_max_x(s_box_max_x), .s_box_max_y(s_box_max_y), .s_box_max_z(s_box_max_z),
        .s_slot_index(s_slot_index),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_accepted(m_accepted), .m_stored_position(m_stored_position),
        .m_evicted_valid(m_evicted_valid), .m_evicted_entity(m_evicted_entity),
        .m_entry_count(m_entry_count), .m_read_entity(m_read_entity),
        .m_read_distance(m_read_distance)
    );

    // Shadow copy of the table and registers
    logic [ENT_W-1:0]  tbl_ent [TABLE_DEPTH];
    logic [DIST_W-1:0] tbl_dist [TABLE_DEPTH];
    int unsigned       tbl_held;
    longint            view [3];
    int unsigned       cap_reg;
    logic              mode_reg;

    entity_item_t pending_items [$];
    selection_t   expected_sel [$];
    int  errors;
    int  n_offers, n_evictions, n_reads, n_drops;
    int  hold_req_seq;
    logic sender_pause;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Four times squared distance, viewer to box centre
    function automatic logic [DIST_W-1:0] centre_dist4(entity_item_t it);
        longint d;
        longint unsigned acc;
        acc = 0;
        for (int a = 0; a < 3; a++) begin
            d = 2 * view[a] - (longint'(it.bmin[a]) + longint'(it.bmax[a]));
            acc += longint'(d * d);
        end
        return acc[DIST_W-1:0];
    endfunction

    // Predict the selection for one accepted item, updating the shadow table
    function automatic selection_t predict_selection(entity_item_t it);
        selection_t r;
        int unsigned cap_eff, best, pos;
        logic [DIST_W-1:0] dist_v, far;
        logic take;
        r = '{default: '0};
        cap_eff = (cap_reg > TABLE_DEPTH) ? TABLE_DEPTH : cap_reg;
        case (it.func)
            FUNC_CLEAR: tbl_held = 0;
            FUNC_OFFER: begin
                n_offers++;
                dist_v = mode_reg ? centre_dist4(it) : '0;
                take = 1'b0;
                pos = 0;
                if (tbl_held < cap_eff) begin
                    pos = tbl_held;
                    tbl_held++;
                    take = 1'b1;
                end else if (mode_reg && tbl_held > 0) begin
                    best = 0;
                    far = tbl_dist[0];
                    for (int i = 1; i < tbl_held; i++)
                        if (tbl_dist[i] > far) begin
                            far = tbl_dist[i];
                            best = i;
                        end
                    if (far > dist_v) begin
                        r.ev_valid = 1'b1;
                        r.ev_ent = tbl_ent[best];
                        n_evictions++;
                        for (int i = best; i + 1 < tbl_held; i++) begin
                            tbl_ent[i] = tbl_ent[i+1];
                            tbl_dist[i] = tbl_dist[i+1];
                        end
                        pos = tbl_held - 1;
                        take = 1'b1;
                    end
                end
                if (take) begin
                    tbl_ent[pos] = it.ent;
                    tbl_dist[pos] = dist_v;
                    r.accepted = 1'b1;
                    r.pos = pos[SLOT_W-1:0];
                end else begin
                    n_drops++;
                end
            end
            FUNC_READ: begin
                n_reads++;
                if (it.slot < tbl_held) begin
                    r.rd_ent = tbl_ent[it.slot];
                    r.rd_dist = tbl_dist[it.slot];
                end
            end
            default: ;
        endcase
        r.count = tbl_held[COUNT_W-1:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Item driver
    int drv_gap;
    entity_item_t drv_cur;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            drv_gap = 0;
        end else begin
            if (s_valid && s_ready)
                expected_sel.push_back(predict_selection(drv_cur));
            if (!s_valid || s_ready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0 && !sender_pause) begin
                    drv_cur = pending_items.pop_front();
                    s_func <= drv_cur.func;
                    s_entity_number <= drv_cur.ent;
                    s_box_min_x <= drv_cur.bmin[0];
                    s_box_min_y <= drv_cur.bmin[1];
                    s_box_min_z <= drv_cur.bmin[2];
                    s_box_max_x <= drv_cur.bmax[0];
                    s_box_max_y <= drv_cur.bmax[1];
                    s_box_max_z <= drv_cur.bmax[2];
                    s_slot_index <= drv_cur.slot;
                    s_valid <= 1'b1;
                    drv_gap = pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v !== act_v) begin
            $display("%0t: mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Result monitor and receiver stalls
    int mon_stall, mon_hold, hold_seen;
    selection_t mon_exp;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            mon_stall = 0;
            mon_hold = 0;
            hold_seen = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_sel.size() == 0) begin
                    $display("%0t: result transfer with nothing expected", $time);
                    errors++;
                end else begin
                    mon_exp = expected_sel.pop_front();
                    check_field("accepted", mon_exp.accepted, m_accepted);
                    check_field("stored_position", mon_exp.pos, m_stored_position);
                    check_field("evicted_valid", mon_exp.ev_valid, m_evicted_valid);
                    check_field("evicted_entity", mon_exp.ev_ent, m_evicted_entity);
                    check_field("entry_count", mon_exp.count, m_entry_count);
                    check_field("read_entity", mon_exp.rd_ent, m_read_entity);
                    check_field("read_distance", mon_exp.rd_dist, m_read_distance);
                end
            end
            if (hold_seen != hold_req_seq) begin
                hold_seen = hold_req_seq;
                mon_hold = 400;
            end
            if (mon_hold > 0) begin
                mon_hold--;
                m_ready <= 1'b0;
            end else if (mon_stall > 0) begin
                mon_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                mon_stall = pick_gap();
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] rand_coord(int spread);
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return COORD_W'(-(1 <<< (COORD_W - 1)));
        if (p == 1) return COORD_W'((1 <<< (COORD_W - 1)) - 1);
        if (p < 5) return COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
        return COORD_W'($signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic entity_item_t make_item(logic [FUNC_W-1:0] f, int spread, int slot_hi);
        entity_item_t it;
        it.func = f;
        it.ent = ENT_W'($urandom_range(0, (1 << ENT_W) - 1));
        for (int a = 0; a < 3; a++) begin
            it.bmin[a] = rand_coord(spread);
            it.bmax[a] = ($urandom_range(0, 3) == 0) ? rand_coord(spread)
                         : it.bmin[a] + COORD_W'($urandom_range(0, 64));
        end
        it.slot = ($urandom_range(0, 3) == 0) ? SLOT_W'($urandom_range(0, 255))
                                              : SLOT_W'($urandom_range(0, slot_hi));
        return it;
    endfunction

    function automatic entity_item_t rand_item(int spread, int slot_hi);
        int p;
        logic [FUNC_W-1:0] f;
        p = $urandom_range(0, 99);
        if (p < 65) f = FUNC_OFFER;
        else if (p < 88) f = FUNC_READ;
        else if (p < 92) f = FUNC_CLEAR;
        else f = FUNC_NOP;
        return make_item(f, spread, slot_hi);
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_valid || expected_sel.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write, only called with the block idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_VIEWER_X: view[0] = longint'($signed(val));
            CFG_VIEWER_Y: view[1] = longint'($signed(val));
            CFG_VIEWER_Z: view[2] = longint'($signed(val));
            CFG_CAPACITY: cap_reg = val[CAP_W-1:0];
            CFG_MODE:     mode_reg = val[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(int vx, int vy, int vz, int cap, bit md);
        wait_idle();
        write_reg(CFG_VIEWER_X, vx[CFG_DATA_W-1:0]);
        write_reg(CFG_VIEWER_Y, vy[CFG_DATA_W-1:0]);
        write_reg(CFG_VIEWER_Z, vz[CFG_DATA_W-1:0]);
        write_reg(CFG_CAPACITY, {10'($urandom_range(0, 1023)), cap[CAP_W-1:0]});
        write_reg(CFG_MODE, {18'($urandom_range(0, 262143)), md});
    endtask

    task automatic run_random(int n, int spread, int slot_hi);
        for (int i = 0; i < n; i++)
            pending_items.push_back(rand_item(spread, slot_hi));
    endtask

    task automatic push_box(logic [FUNC_W-1:0] f, int ent, int lo, int hi, int slot);
        entity_item_t it;
        it.func = f;
        it.ent = ENT_W'(ent);
        for (int a = 0; a < 3; a++) begin
            it.bmin[a] = COORD_W'(lo);
            it.bmax[a] = COORD_W'(hi);
        end
        it.slot = SLOT_W'(slot);
        pending_items.push_back(it);
    endtask

    // Stimulus
    int caps [12] = '{1, 2, 3, 5, 8, 13, 64, 0, 300, 511, 4, 256};
    initial begin
        errors = 0;
        n_offers = 0; n_evictions = 0; n_reads = 0; n_drops = 0;
        hold_req_seq = 0;
        sender_pause = 1'b0;
        view = '{0, 0, 0};
        cap_reg = 64;
        mode_reg = 1'b1;
        tbl_held = 0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        s_func = FUNC_NOP; s_entity_number = '0; s_slot_index = '0;
        s_box_min_x = '0; s_box_min_y = '0; s_box_min_z = '0;
        s_box_max_x = '0; s_box_max_y = '0; s_box_max_z = '0;
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: defaults, extremes, inverted box, empty reads, no-op
        push_box(FUNC_READ, 0, 0, 0, 0);
        push_box(FUNC_NOP, 0, 0, 0, 0);
        push_box(FUNC_OFFER, 0, -262144, -262144, 0);
        push_box(FUNC_OFFER, 2047, 262143, 262143, 0);
        push_box(FUNC_OFFER, 5, 262143, -262144, 0);
        push_box(FUNC_READ, 0, 0, 0, 0);
        push_box(FUNC_READ, 0, 0, 0, 2);
        push_box(FUNC_READ, 0, 0, 0, 255);
        push_box(FUNC_CLEAR, 0, 0, 0, 0);
        push_box(FUNC_READ, 0, 0, 0, 0);
        // Two slots: fill, a tie with the farthest is dropped, a farther offer is dropped
        set_config(-262144, 262143, 0, 2, 1'b1);
        push_box(FUNC_OFFER, 10, 100, 200, 0);
        push_box(FUNC_OFFER, 11, 300, 400, 0);
        push_box(FUNC_OFFER, 12, 300, 400, 0);
        push_box(FUNC_OFFER, 13, -262144, -262144, 0);
        push_box(FUNC_READ, 0, 0, 0, 1);
        // Lower capacity below the count, then zero capacity, then plain mode
        set_config(0, 0, 0, 1, 1'b1);
        push_box(FUNC_OFFER, 20, 0, 0, 0);
        push_box(FUNC_READ, 0, 0, 0, 1);
        set_config(0, 0, 0, 0, 1'b1);
        push_box(FUNC_OFFER, 21, 0, 0, 0);
        set_config(0, 0, 0, 2, 1'b0);
        push_box(FUNC_CLEAR, 0, 0, 0, 0);
        push_box(FUNC_OFFER, 22, 5, 9, 0);
        push_box(FUNC_OFFER, 23, 5, 9, 0);
        push_box(FUNC_OFFER, 24, 5, 9, 0);
        push_box(FUNC_READ, 0, 0, 0, 0);

        // Random phases over a range of settings
        for (int ph = 0; ph < 12; ph++) begin
            set_config($urandom_range(0, 524287) - 262144, $urandom_range(0, 1000) - 500,
                       (ph % 3 == 0) ? 262143 : -262144, caps[ph], (ph != 5));
            if (ph == 7 || ph == 9)
                run_random(40, 2000, 20);
            else if (caps[ph] >= 256)
                run_random(150, 100000, 255);
            else
                run_random(120, (ph % 2) ? 50 : 100000, caps[ph] + 1);
            if (ph == 3) begin
                // Receiver holds off while items keep coming
                hold_req_seq++;
                run_random(60, 300, 8);
            end
            if (ph == 6) begin
                // Filled table, then a smaller capacity without a clear
                wait_idle();
                write_reg(CFG_CAPACITY, CFG_DATA_W'(3));
                run_random(80, 1000, 70);
            end
            if (ph == 10) begin
                sender_pause = 1'b1;
                while (s_valid || expected_sel.size() > 0) @(posedge aclk);
                sender_pause = 1'b0;
                run_random(60, 500, 5);
            end
        end

        wait_idle();
        $display("Covered %0d offers (%0d evictions, %0d dropped) and %0d slot reads",
                 n_offers, n_evictions, n_drops, n_reads);
        $display("over several viewer, capacity and mode settings with random stalls.");
        if (errors == 0) begin
            $display("PASS nearest_k_entity_selector");
        end else begin
            $display("FAIL nearest_k_entity_selector");
        end
        $finish;
    end

    // Run limit
    initial begin
        #40000000;
        $display("FAIL nearest_k_entity_selector");
        $finish;
    end

endmodule
